### rtl/core/tal_pkg.sv
// ----------------------------------------------------------------------------
// tal_pkg
// Shared constants and types for the tree ancestor lifting core.
// ----------------------------------------------------------------------------
package tal_pkg;
	localparam int MaxNodes = 1024;
	localparam int Levels = 11;
	localparam int NodeW = 11;
	localparam int LvlW = 4;
	localparam int DepthAw = 11;
	localparam int DepthEntries = 1 << DepthAw;
	localparam int JumpAw = 15;
	localparam int JumpEntries = 1 << JumpAw;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_KTH = 2'd1;
	localparam logic [1:0] REQ_LCA = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_INSERT = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [NodeW-1:0] node_a;
		logic [9:0] parent_id;
		logic [NodeW-1:0] node_b;
		logic [NodeW-1:0] distance;
	} req_t;

	typedef struct packed {
		logic found;
		logic [NodeW-1:0] answer_node;
		logic [1:0] status;
	} rsp_t;

	function automatic logic [JumpAw-1:0] jaddr(input logic [NodeW-1:0] n,
			input logic [LvlW-1:0] l);
		jaddr = {n, l};
	endfunction
endpackage

### rtl/core/tal_ram.sv
// ----------------------------------------------------------------------------
// tal_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tal_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/core/tal_engine.sv
// ----------------------------------------------------------------------------
// tal_engine
// Sequencer that runs inserts, ancestor and common ancestor requests one
// table read per cycle against the depth and jump memories.
// ----------------------------------------------------------------------------
module tal_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  tal_pkg::req_t                   req,
	output logic                            busy,
	output logic                            done,
	output tal_pkg::rsp_t                   rsp,
	output logic                            d_we,
	output logic [tal_pkg::DepthAw-1:0]     d_waddr,
	output logic [tal_pkg::NodeW-1:0]       d_wdata,
	output logic [tal_pkg::DepthAw-1:0]     d_raddr,
	input  logic [tal_pkg::NodeW-1:0]       d_rdata,
	output logic                            j_we,
	output logic [tal_pkg::JumpAw-1:0]      j_waddr,
	output logic [tal_pkg::NodeW-1:0]       j_wdata,
	output logic [tal_pkg::JumpAw-1:0]      j_raddr,
	input  logic [tal_pkg::NodeW-1:0]       j_rdata
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_INS0 = 4'd1;
	localparam logic [3:0] S_INSR = 4'd2;
	localparam logic [3:0] S_INSW = 4'd3;
	localparam logic [3:0] S_DEPA = 4'd4;
	localparam logic [3:0] S_DEPB = 4'd5;
	localparam logic [3:0] S_SPLIT = 4'd6;
	localparam logic [3:0] S_CR = 4'd7;
	localparam logic [3:0] S_CW = 4'd8;
	localparam logic [3:0] S_LU = 4'd9;
	localparam logic [3:0] S_LV = 4'd10;
	localparam logic [3:0] S_LX = 4'd11;
	localparam logic [3:0] S_LF = 4'd12;
	localparam logic [3:0] S_LG = 4'd13;
	localparam logic [3:0] S_DONE = 4'd14;

	localparam int NW = tal_pkg::NodeW;
	localparam logic [tal_pkg::LvlW-1:0] TopLvl = tal_pkg::LvlW'(tal_pkg::Levels - 1);

	logic [3:0] state_q;
	tal_pkg::req_t req_q;
	logic [NW-1:0] count_q;
	logic [NW-1:0] u_q, v_q, ju_q, dist_q, da_q;
	logic [tal_pkg::LvlW-1:0] lvl_q;
	tal_pkg::rsp_t rsp_q;

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign rsp = rsp_q;

	function automatic logic known(input logic [NW-1:0] n, input logic [NW-1:0] c);
		known = (n != '0) && (n <= c);
	endfunction

	function automatic logic insert_ok(input tal_pkg::req_t r, input logic [NW-1:0] c);
		logic parent_ok;
		parent_ok = (r.node_a == NW'(1)) ? (r.parent_id == '0) :
			((r.parent_id != '0) && (NW'(r.parent_id) < r.node_a));
		insert_ok = (r.node_a == c + NW'(1)) &&
			(r.node_a <= NW'(tal_pkg::MaxNodes)) && parent_ok;
	endfunction

	always_comb begin
		d_we = 1'b0;
		d_waddr = req_q.node_a;
		d_wdata = '0;
		d_raddr = req_q.node_a;
		j_we = 1'b0;
		j_waddr = tal_pkg::jaddr(req_q.node_a, lvl_q);
		j_wdata = NW'(req_q.parent_id);
		j_raddr = tal_pkg::jaddr(u_q, lvl_q);
		case (state_q)
			S_INS0: begin
				d_raddr = NW'(req_q.parent_id);
				j_we = 1'b1;
			end
			S_INSR: begin
				j_raddr = tal_pkg::jaddr(u_q, lvl_q - 1'b1);
				if (lvl_q == tal_pkg::LvlW'(1)) begin
					d_we = 1'b1;
					d_wdata = (req_q.node_a == NW'(1)) ? '0 : d_rdata + NW'(1);
				end
			end
			S_INSW: begin
				j_we = 1'b1;
				j_wdata = (u_q == '0) ? '0 : j_rdata;
			end
			S_DEPB: d_raddr = req_q.node_b;
			S_LV: j_raddr = tal_pkg::jaddr(v_q, lvl_q);
			S_LF: j_raddr = tal_pkg::jaddr(u_q, tal_pkg::LvlW'(0));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			req_q <= '0;
			rsp_q <= '0;
			u_q <= '0;
			v_q <= '0;
			ju_q <= '0;
			dist_q <= '0;
			da_q <= '0;
			lvl_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q <= req;
						rsp_q <= '{found: 1'b0, answer_node: '0, status: tal_pkg::ST_OK};
						lvl_q <= '0;
						u_q <= NW'(req.parent_id);
						case (req.req_type)
							tal_pkg::REQ_INSERT: begin
								if (insert_ok(req, count_q)) begin
									state_q <= S_INS0;
								end else begin
									rsp_q.status <= tal_pkg::ST_BAD_INSERT;
									state_q <= S_DONE;
								end
							end
							tal_pkg::REQ_KTH: begin
								if (known(req.node_a, count_q)) begin
									state_q <= S_DEPA;
								end else begin
									rsp_q.status <= tal_pkg::ST_UNKNOWN;
									state_q <= S_DONE;
								end
							end
							tal_pkg::REQ_LCA: begin
								if (known(req.node_a, count_q) && known(req.node_b, count_q)) begin
									state_q <= S_DEPA;
								end else begin
									rsp_q.status <= tal_pkg::ST_UNKNOWN;
									state_q <= S_DONE;
								end
							end
							default: begin
								rsp_q.status <= tal_pkg::ST_UNKNOWN;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_INS0: begin
					lvl_q <= tal_pkg::LvlW'(1);
					state_q <= S_INSR;
				end
				S_INSR: state_q <= S_INSW;
				S_INSW: begin
					u_q <= j_wdata;
					if (lvl_q == TopLvl) begin
						count_q <= req_q.node_a;
						state_q <= S_DONE;
					end else begin
						lvl_q <= lvl_q + 1'b1;
						state_q <= S_INSR;
					end
				end
				S_DEPA: state_q <= S_DEPB;
				S_DEPB: begin
					da_q <= d_rdata;
					lvl_q <= '0;
					if (req_q.req_type == tal_pkg::REQ_KTH) begin
						u_q <= req_q.node_a;
						dist_q <= req_q.distance;
						if (req_q.distance > d_rdata) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_CR;
						end
					end else begin
						state_q <= S_SPLIT;
					end
				end
				S_SPLIT: begin
					lvl_q <= '0;
					state_q <= S_CR;
					if (da_q >= d_rdata) begin
						u_q <= req_q.node_a;
						v_q <= req_q.node_b;
						dist_q <= da_q - d_rdata;
					end else begin
						u_q <= req_q.node_b;
						v_q <= req_q.node_a;
						dist_q <= d_rdata - da_q;
					end
				end
				S_CR: begin
					if (lvl_q == TopLvl) begin
						if (req_q.req_type == tal_pkg::REQ_KTH || u_q == v_q) begin
							rsp_q.found <= (u_q != '0);
							rsp_q.answer_node <= u_q;
							state_q <= S_DONE;
						end else begin
							state_q <= S_LU;
						end
					end else if (dist_q[lvl_q]) begin
						state_q <= S_CW;
					end else begin
						lvl_q <= lvl_q + 1'b1;
					end
				end
				S_CW: begin
					u_q <= j_rdata;
					lvl_q <= lvl_q + 1'b1;
					state_q <= S_CR;
				end
				S_LU: state_q <= S_LV;
				S_LV: begin
					ju_q <= j_rdata;
					state_q <= S_LX;
				end
				S_LX: begin
					if (ju_q != j_rdata) begin
						u_q <= ju_q;
						v_q <= j_rdata;
					end
					if (lvl_q == '0) begin
						state_q <= S_LF;
					end else begin
						lvl_q <= lvl_q - 1'b1;
						state_q <= S_LU;
					end
				end
				S_LF: state_q <= S_LG;
				S_LG: begin
					rsp_q.found <= (j_rdata != '0);
					rsp_q.answer_node <= j_rdata;
					state_q <= S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### rtl/core/tree_ancestor_lifting_core.sv
// ----------------------------------------------------------------------------
// tree_ancestor_lifting_core
// Binary lifting tree: inserts, k-th ancestor and lowest common ancestor requests.
// ----------------------------------------------------------------------------
// Channel | Dir | Contents
// s_axis  | in  | tdata: req_type, node_a, parent_id, node_b, distance
// m_axis  | out | tdata: found, answer_node, status
// Each request steps through the jump memory one access a cycle: an insert
// reads and then writes one entry per level, and a common ancestor lift
// reads the entries of both nodes per level and then compares them.
// One request is in work at a time; the result waits in an output register
// and the input is held off until it is taken.
// Reset clears the node count; table contents need no clearing.
module tree_ancestor_lifting_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata, // req_type, node_a, parent_id, node_b, distance
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata  // found, answer_node, status
);
	tal_pkg::req_t req;
	tal_pkg::rsp_t rsp;
	logic busy, done, out_q;
	logic [15:0] out_data_q;
	logic d_we, j_we;
	logic [tal_pkg::DepthAw-1:0] d_waddr, d_raddr;
	logic [tal_pkg::NodeW-1:0] d_wdata, d_rdata, j_wdata, j_rdata;
	logic [tal_pkg::JumpAw-1:0] j_waddr, j_raddr;

	assign req.req_type = s_axis_tdata[1:0];
	assign req.node_a = s_axis_tdata[12:2];
	assign req.parent_id = s_axis_tdata[22:13];
	assign req.node_b = s_axis_tdata[33:23];
	assign req.distance = s_axis_tdata[44:34];

	assign s_axis_tready = !busy && !out_q;
	assign m_axis_tvalid = out_q;
	assign m_axis_tdata = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= 1'b0;
		end else if (done) begin
			out_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_data_q <= {2'b00, rsp.status, rsp.answer_node, rsp.found};
		end
	end

	tal_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.start(s_axis_tvalid && s_axis_tready), .req(req),
		.busy(busy), .done(done), .rsp(rsp),
		.d_we(d_we), .d_waddr(d_waddr), .d_wdata(d_wdata),
		.d_raddr(d_raddr), .d_rdata(d_rdata),
		.j_we(j_we), .j_waddr(j_waddr), .j_wdata(j_wdata),
		.j_raddr(j_raddr), .j_rdata(j_rdata)
	);

	tal_ram #(.Width(tal_pkg::NodeW), .Depth(tal_pkg::DepthEntries)) u_depth (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata)
	);

	tal_ram #(.Width(tal_pkg::NodeW), .Depth(tal_pkg::JumpEntries)) u_jump (
		.clk(clk), .we(j_we), .waddr(j_waddr), .wdata(j_wdata),
		.raddr(j_raddr), .rdata(j_rdata)
	);
endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Random and directed test of the tree ancestor lifting core. Inserts, k-th
// ancestor and common ancestor requests are checked against a predictor that
// keeps its own depth and jump tables, across phases of sender and receiver
// idling.
// ----------------------------------------------------------------------------
module tb_top;
	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam int CycleLimit = 1000000;
	localparam int PhaseItems = 490;
	localparam int GapPct [4] = '{0, 49, 0, 31};
	localparam int StallPct [4] = '{0, 0, 49, 31};

	typedef struct {
		logic [1:0] kind;
		logic [tal_pkg::NodeW-1:0] a;
		logic [9:0] p;
		logic [tal_pkg::NodeW-1:0] b;
		logic [tal_pkg::NodeW-1:0] hops;
	} lift_req_t;

	typedef struct {
		logic found;
		logic [tal_pkg::NodeW-1:0] node;
		logic [1:0] status;
	} lift_rsp_t;

	function automatic bit insert_ok(int a, int p, int count);
		if (a != count + 1 || a > tal_pkg::MaxNodes) return 0;
		if (a == 1) return p == 0;
		return p >= 1 && p < a;
	endfunction

	class lift_scoreboard;
		int unsigned depth_of [tal_pkg::MaxNodes+1];
		logic [tal_pkg::NodeW-1:0] hop [tal_pkg::MaxNodes+1][tal_pkg::Levels];
		int count;
		int errors;
		lift_rsp_t answers_due [$];

		function logic [tal_pkg::NodeW-1:0] jump_up(int n, int l);
			if (n == 0 || n > tal_pkg::MaxNodes || l >= tal_pkg::Levels) return '0;
			return hop[n][l];
		endfunction

		function int climb(int n, int d);
			int i;
			while (n != 0 && d >= (1 << (tal_pkg::Levels - 1))) begin
				n = jump_up(n, tal_pkg::Levels - 1);
				d -= 1 << (tal_pkg::Levels - 1);
			end
			for (i = tal_pkg::Levels - 2; i >= 0; i--) begin
				if ((d >> i) & 1) n = jump_up(n, i);
			end
			return n;
		endfunction

		function bit known(int n);
			return n >= 1 && n <= count;
		endfunction

		function void note_request(lift_req_t r);
			lift_rsp_t e;
			int a, b, u, v, t, i, ju, jv;
			a = r.a;
			b = r.b;
			e.found = 0;
			e.node = '0;
			e.status = tal_pkg::ST_OK;
			case (r.kind)
				tal_pkg::REQ_INSERT: begin
					if (!insert_ok(a, r.p, count)) begin
						e.status = tal_pkg::ST_BAD_INSERT;
					end else begin
						depth_of[a] = (a == 1) ? 0 : depth_of[r.p] + 1;
						hop[a][0] = tal_pkg::NodeW'(r.p);
						for (i = 1; i < tal_pkg::Levels; i++)
							hop[a][i] = jump_up(hop[a][i-1], i - 1);
						count = a;
					end
				end
				tal_pkg::REQ_KTH: begin
					if (!known(a)) begin
						e.status = tal_pkg::ST_UNKNOWN;
					end else if (r.hops <= depth_of[a]) begin
						e.node = tal_pkg::NodeW'(climb(a, r.hops));
						e.found = e.node != 0;
					end
				end
				tal_pkg::REQ_LCA: begin
					if (!known(a) || !known(b)) begin
						e.status = tal_pkg::ST_UNKNOWN;
					end else begin
						u = a;
						v = b;
						if (depth_of[u] < depth_of[v]) begin
							t = u;
							u = v;
							v = t;
						end
						u = climb(u, depth_of[u] - depth_of[v]);
						if (u != v) begin
							for (i = tal_pkg::Levels - 1; i >= 0; i--) begin
								ju = jump_up(u, i);
								jv = jump_up(v, i);
								if (ju != jv) begin
									u = ju;
									v = jv;
								end
							end
							u = jump_up(u, 0);
						end
						e.node = tal_pkg::NodeW'(u);
						e.found = u != 0;
					end
				end
				default: e.status = tal_pkg::ST_UNKNOWN;
			endcase
			answers_due = {answers_due, e};
		endfunction

		function void check_response(lift_rsp_t r);
			lift_rsp_t e;
			if (answers_due.size() == 0) begin
				$error("unexpected response found=%0d answer_node=%0d status=%0d",
					r.found, r.node, r.status);
				errors++;
				return;
			end
			e = answers_due.pop_front();
			if (r.found !== e.found) begin
				$error("found: expected %0d, actual %0d", e.found, r.found);
				errors++;
			end
			if (r.node !== e.node) begin
				$error("answer_node: expected %0d, actual %0d", e.node, r.node);
				errors++;
			end
			if (r.status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, r.status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [15:0] m_axis_tdata;

	lift_scoreboard lift_sb = new();
	int gen_count = 0;
	int send_gap_pct = 0;
	int stall_pct = 0;
	bit hold_armed = 0;
	bit hold_taken = 0;
	int hold_cycles = 0;
	int cycles = 0;

	always #5 clk = ~clk;

	tree_ancestor_lifting_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always @(posedge clk) begin
		lift_req_t r;
		lift_rsp_t o;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			r.kind = s_axis_tdata[1:0];
			r.a = s_axis_tdata[12:2];
			r.p = s_axis_tdata[22:13];
			r.b = s_axis_tdata[33:23];
			r.hops = s_axis_tdata[44:34];
			lift_sb.note_request(r);
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			o.found = m_axis_tdata[0];
			o.node = m_axis_tdata[11:1];
			o.status = m_axis_tdata[13:12];
			lift_sb.check_response(o);
		end
	end

	always @(posedge clk) begin
		if (hold_armed && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_cycles <= 400;
			m_axis_tready <= 0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= arst_n && ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("tree_ancestor_lifting_core: mismatch");
			$finish;
		end
	end

	task automatic send_request(logic [1:0] kind, int a, int p, int b, int hops);
		if (insert_ok(a, p, gen_count) && kind == tal_pkg::REQ_INSERT) gen_count = a;
		if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {3'b000, hops[10:0], b[10:0], p[9:0], a[10:0], kind};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	function automatic int pick_node();
		if (gen_count == 0 || $urandom_range(9) == 0) return $urandom_range(0, 2047);
		if ($urandom_range(3) == 0) return gen_count;
		return $urandom_range(1, gen_count);
	endfunction

	task automatic send_random();
		int r, a, p, d;
		r = $urandom_range(99);
		if (r < 42 && gen_count < tal_pkg::MaxNodes) begin
			a = gen_count + 1;
			case ($urandom_range(2))
				0: p = a - 1;
				1: p = a - 1 - $urandom_range(0, 3);
				default: p = $urandom_range(1, a);
			endcase
			if (a == 1) p = 0;
			if (p < 1 && a > 1) p = 1;
			if (p >= a && a > 1) p = a - 1;
			send_request(tal_pkg::REQ_INSERT, a, p, $urandom_range(0, 2047),
				$urandom_range(0, 2047));
		end else if (r < 48) begin
			send_request(tal_pkg::REQ_INSERT, pick_node(), $urandom_range(0, 1023),
				$urandom_range(0, 2047), $urandom_range(0, 2047));
		end else if (r < 74) begin
			case ($urandom_range(3))
				0: d = $urandom_range(0, 2047);
				1: d = $urandom_range(0, 600);
				default: d = $urandom_range(0, 40);
			endcase
			send_request(tal_pkg::REQ_KTH, pick_node(), $urandom_range(0, 1023),
				$urandom_range(0, 2047), d);
		end else if (r < 97) begin
			send_request(tal_pkg::REQ_LCA, pick_node(), $urandom_range(0, 1023), pick_node(),
				$urandom_range(0, 2047));
		end else begin
			send_request(REQ_SPARE, $urandom_range(0, 2047), $urandom_range(0, 1023),
				$urandom_range(0, 2047), $urandom_range(0, 2047));
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (lift_sb.answers_due.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	initial begin
		int ph, n;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_request(tal_pkg::REQ_KTH, 1, 0, 1, 0);
		send_request(tal_pkg::REQ_LCA, 1, 0, 1, 0);
		send_request(tal_pkg::REQ_INSERT, 2, 0, 0, 0);
		send_request(tal_pkg::REQ_INSERT, 1, 1023, 0, 0);
		send_request(tal_pkg::REQ_INSERT, 1, 0, 2047, 2047);
		send_request(tal_pkg::REQ_INSERT, 1, 0, 0, 0);
		send_request(tal_pkg::REQ_INSERT, 2, 2, 0, 0);
		send_request(tal_pkg::REQ_INSERT, 2, 0, 0, 0);
		send_request(tal_pkg::REQ_INSERT, 2, 1, 0, 0);
		send_request(tal_pkg::REQ_INSERT, 3, 1, 0, 0);
		send_request(tal_pkg::REQ_INSERT, 4, 2, 0, 0);
		send_request(tal_pkg::REQ_INSERT, 5, 4, 0, 0);
		send_request(tal_pkg::REQ_KTH, 5, 0, 0, 0);
		send_request(tal_pkg::REQ_KTH, 5, 0, 0, 3);
		send_request(tal_pkg::REQ_KTH, 5, 0, 0, 4);
		send_request(tal_pkg::REQ_KTH, 5, 0, 0, 2047);
		send_request(tal_pkg::REQ_KTH, 0, 0, 0, 1);
		send_request(tal_pkg::REQ_KTH, 2047, 1023, 2047, 1);
		send_request(tal_pkg::REQ_LCA, 5, 0, 3, 0);
		send_request(tal_pkg::REQ_LCA, 4, 0, 5, 0);
		send_request(tal_pkg::REQ_LCA, 5, 0, 5, 0);
		send_request(tal_pkg::REQ_LCA, 5, 0, 1024, 0);
		send_request(REQ_SPARE, 1, 0, 1, 1);
		drain();

		for (ph = 0; ph < 4; ph++) begin
			send_gap_pct = GapPct[ph];
			stall_pct = StallPct[ph];
			if (ph == 2) hold_armed = 1;
			for (n = 0; n < PhaseItems; n++) send_random();
			drain();
		end

		if (lift_sb.answers_due.size() != 0) begin
			$error("%0d responses never arrived", lift_sb.answers_due.size());
			lift_sb.errors++;
		end
		if (lift_sb.errors == 0) begin
			$display("tree_ancestor_lifting_core: match");
		end else begin
			$display("tree_ancestor_lifting_core: mismatch");
		end
		$finish;
	end
endmodule
